// File: src/amrt_pkg.sv
// Package for the matrix rotate/transform unit: number formats, angle constants,
// the CORDIC arctangent table, the state encoding and the shift-and-saturate helper.
// No dependencies.
`timescale 1ns / 1ps

package amrt_pkg;

    localparam int WORD_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int CORDIC_N = 18;
    localparam int AXIS_W   = 16;
    localparam int PROD_W   = 2 * WORD_W;
    localparam int ACC_W    = PROD_W + 3;
    localparam int RM_W     = 24;
    localparam int RM_SHIFT = 28;
    localparam int AX_SHIFT = 14;
    localparam int RED_W    = WORD_W + 2;
    localparam int RED_STEPS = 14;
    localparam int CNT_W    = 5;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI_W  = (PI_Q60 + (64'd1 << (59 - FRAC_W))) >> (60 - FRAC_W);
    localparam logic [63:0] TPI_W = (PI_Q60 + (64'd1 << (58 - FRAC_W))) >> (59 - FRAC_W);
    localparam logic [63:0] HPI_W = (PI_Q60 + (64'd1 << (60 - FRAC_W))) >> (61 - FRAC_W);
    localparam logic signed [RED_W-1:0] PI_R  = RED_W'(PI_W);
    localparam logic signed [RED_W-1:0] TPI_R = RED_W'(TPI_W);
    localparam logic signed [RED_W-1:0] HPI_R = RED_W'(HPI_W);

    localparam logic signed [WORD_W-1:0] ONE_W = WORD_W'(64'd1 << FRAC_W);
    localparam logic [63:0] GAIN_Q30 = 64'h26DD3B6A;
    localparam logic signed [WORD_W-1:0] X_INIT =
        WORD_W'((GAIN_Q30 + (64'd1 << (29 - FRAC_W))) >> (30 - FRAC_W));

    localparam logic signed [ACC_W-FRAC_W-1:0] SH_MAX = (ACC_W-FRAC_W)'((64'd1 << (WORD_W-1)) - 1);
    localparam logic signed [ACC_W-FRAC_W-1:0] SH_MIN = -SH_MAX - 1;

    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_ROTATE = 2'd1;
    localparam logic [1:0] KIND_VERTEX = 2'd2;
    localparam logic [1:0] KIND_NORMAL = 2'd3;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_REDUCE = 8'b0000_0010,
        ST_FOLD   = 8'b0000_0100,
        ST_CORDIC = 8'b0000_1000,
        ST_COEF   = 8'b0001_0000,
        ST_MATMUL = 8'b0010_0000,
        ST_COMMIT = 8'b0100_0000,
        ST_XFORM  = 8'b1000_0000
    } t_state;

    function automatic logic signed [WORD_W-1:0] atan_frac(input logic [CNT_W-1:0] idx);
        logic [31:0] q;
        case (idx)
            5'd0:  q = 32'h3243F6A8;
            5'd1:  q = 32'h1DAC6705;
            5'd2:  q = 32'h0FADBAFC;
            5'd3:  q = 32'h07F56EA6;
            5'd4:  q = 32'h03FEAB76;
            5'd5:  q = 32'h01FFD55B;
            5'd6:  q = 32'h00FFFAAA;
            5'd7:  q = 32'h007FFF55;
            5'd8:  q = 32'h003FFFEA;
            5'd9:  q = 32'h001FFFFD;
            5'd10: q = 32'h000FFFFF;
            5'd11: q = 32'h0007FFFF;
            5'd12: q = 32'h0003FFFF;
            5'd13: q = 32'h0001FFFF;
            5'd14: q = 32'h0000FFFF;
            5'd15: q = 32'h00007FFF;
            5'd16: q = 32'h00003FFF;
            5'd17: q = 32'h00001FFF;
            5'd18: q = 32'h00000FFF;
            5'd19: q = 32'h000007FF;
            5'd20: q = 32'h000003FF;
            5'd21: q = 32'h000001FF;
            5'd22: q = 32'h000000FF;
            5'd23: q = 32'h0000007F;
            5'd24: q = 32'h0000003F;
            5'd25: q = 32'h0000001F;
            5'd26: q = 32'h0000000F;
            5'd27: q = 32'h00000008;
            5'd28: q = 32'h00000004;
            5'd29: q = 32'h00000002;
            default: q = 32'h00000000;
        endcase
        return WORD_W'((q + (32'd1 << (29 - FRAC_W))) >> (30 - FRAC_W));
    endfunction

    // Floor shift by the fraction width, then saturate to the word range.
    function automatic logic signed [WORD_W-1:0] finish_word(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-FRAC_W-1:0] sh;
        sh = (ACC_W-FRAC_W)'(a >>> FRAC_W);
        if (sh > SH_MAX) return SH_MAX[WORD_W-1:0];
        if (sh < SH_MIN) return SH_MIN[WORD_W-1:0];
        return sh[WORD_W-1:0];
    endfunction

endpackage

// File: src/affine_matrix_rotate_transform_unit.sv
// Top level of the model-view matrix unit: matrix storage, angle reduction, CORDIC,
// and one shared 32x32 multiplier with accumulator under a small sequencer.
// Depends on amrt_pkg.
`timescale 1ns / 1ps

// Sequence: an entry write completes in the cycle it is accepted and never raises busy.
// A vertex or normal transform works through three rows, each a multiply and an accumulate
// phase per product (four for a vertex, three for a normal) plus one store phase; o_valid then pulses.
// A rotation runs 14 reduction steps, one fold, 18 CORDIC steps and one step to latch sine and
// cosine, then the nine coefficients, the nine new entries and one commit.
// Reset is synchronous, active low; it loads the identity matrix. The receiver cannot stall.
module affine_matrix_rotate_transform_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_kind,
    input  logic [3:0]                         i_entry_index,
    input  logic signed [amrt_pkg::WORD_W-1:0] i_entry_value,
    input  logic signed [amrt_pkg::WORD_W-1:0] i_angle,
    input  logic signed [amrt_pkg::AXIS_W-1:0] i_axis_x,
    input  logic signed [amrt_pkg::AXIS_W-1:0] i_axis_y,
    input  logic signed [amrt_pkg::AXIS_W-1:0] i_axis_z,
    input  logic signed [amrt_pkg::WORD_W-1:0] i_vec_x,
    input  logic signed [amrt_pkg::WORD_W-1:0] i_vec_y,
    input  logic signed [amrt_pkg::WORD_W-1:0] i_vec_z,
    output logic                               o_valid,
    output logic signed [amrt_pkg::WORD_W-1:0] o_out_x,
    output logic signed [amrt_pkg::WORD_W-1:0] o_out_y,
    output logic signed [amrt_pkg::WORD_W-1:0] o_out_z
);
    import amrt_pkg::*;

    // Sequencer state and counters. r_row/r_col walk the 3x3 grid, r_sub picks the
    // product within a dot product, r_ph splits a product into multiply, accumulate
    // and (after the last product) shift-and-store.
    t_state r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [1:0] r_row, r_col, r_sub, r_ph;
    logic r_vert, r_neg, r_flip, r_valid;

    // Matrix, column-major, entry = column*4 + row.
    logic signed [WORD_W-1:0] r_mat [16];
    logic signed [WORD_W-1:0] r_newm [3][3];
    logic signed [RM_W-1:0]   r_rm [3][3];
    logic signed [WORD_W-1:0] r_v [3];
    logic signed [WORD_W-1:0] r_res [3];
    logic signed [AXIS_W-1:0] r_ax [3];

    logic [RED_W-1:0] r_mag;
    logic signed [WORD_W-1:0] r_x, r_y, r_z, r_s, r_c, r_t, r_tmp;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;

    logic accept;
    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_out_x = r_res[0];
    assign o_out_y = r_res[1];
    assign o_out_z = r_res[2];

    // Off-diagonal coefficient helpers: other_ax is the third axis, plus selects +s*axis.
    // On the diagonal the axis product is not used, so the index stays in range.
    logic [1:0] other_ax, col_next;
    logic diag, plus;
    assign other_ax = diag ? r_row : 2'(3'd3 - {1'b0, r_row} - {1'b0, r_col});
    assign col_next = (r_col == 2'd2) ? 2'd0 : r_col + 2'd1;
    assign diag = (r_row == r_col);
    assign plus = (col_next == r_row);

    // Shared multiplier operands.
    logic signed [WORD_W-1:0] mul_a, mul_b, mat_rd;
    logic signed [PROD_W-1:0] mul_p;
    logic [1:0] last_sub;
    assign mat_rd = r_mat[{r_sub, r_row}];

    always_comb begin
        mul_a = mat_rd;
        mul_b = ONE_W;
        last_sub = 2'd2;
        unique case (r_state)
            ST_COEF: begin
                case (r_sub)
                    2'd0: begin
                        mul_a = WORD_W'(r_ax[r_row]);
                        mul_b = WORD_W'(r_ax[r_col]);
                    end
                    2'd1: begin
                        mul_a = r_tmp;
                        mul_b = r_t;
                    end
                    default: begin
                        mul_a = WORD_W'(r_ax[other_ax]);
                        mul_b = r_s;
                    end
                endcase
            end
            ST_MATMUL: begin
                mul_b = WORD_W'(r_rm[r_sub][r_col]);
            end
            ST_XFORM: begin
                last_sub = r_vert ? 2'd3 : 2'd2;
                mul_b = (r_sub == 2'd3) ? ONE_W : r_v[r_sub];
            end
            default: begin
                mul_b = ONE_W;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Angle reduction and fold into [-pi/2, pi/2].
    logic [RED_W-1:0] red_sub;
    logic signed [RED_W-1:0] f1, f2, f3;
    logic f_flip;
    assign red_sub = RED_W'(TPI_R) << r_cnt;
    always_comb begin
        f1 = (r_neg && (r_mag != '0)) ? TPI_R - $signed(r_mag) : $signed(r_mag);
        f2 = (f1 >= PI_R) ? f1 - TPI_R : f1;
        f_flip = 1'b0;
        f3 = f2;
        if (f2 > HPI_R) begin
            f3 = f2 - PI_R;
            f_flip = 1'b1;
        end else if (f2 < -HPI_R) begin
            f3 = f2 + PI_R;
            f_flip = 1'b1;
        end
    end

    // CORDIC step and the final sine and cosine.
    logic signed [WORD_W-1:0] xs, ys, at, c_fin;
    assign xs = r_x >>> r_cnt;
    assign ys = r_y >>> r_cnt;
    assign at = atan_frac(r_cnt);
    assign c_fin = r_flip ? -r_x : r_x;

    // Accumulate the registered product.
    logic signed [ACC_W-1:0] prod_ext, acc_next;
    assign prod_ext = ACC_W'(r_prod);
    always_comb begin
        acc_next = r_acc + prod_ext;
        if (r_state == ST_COEF) begin
            if (r_sub == 2'd1) acc_next = prod_ext;
            else if (diag) acc_next = r_acc + (ACC_W'(r_c) <<< RM_SHIFT);
            else if (plus) acc_next = r_acc + (prod_ext <<< AX_SHIFT);
            else acc_next = r_acc - (prod_ext <<< AX_SHIFT);
        end else if (r_sub == 2'd0) begin
            acc_next = prod_ext;
        end
    end

    logic signed [WORD_W-1:0] fin;
    assign fin = finish_word(r_acc);
    logic grid_last;
    assign grid_last = (r_row == 2'd2) && (r_col == 2'd2);

    // The result strobe follows the cycle that stores the last row of a transform.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == ST_XFORM) && (r_ph == 2'd2) && (r_row == 2'd2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt <= '0;
            r_row <= '0;
            r_col <= '0;
            r_sub <= '0;
            r_ph <= '0;
            for (int n = 0; n < 16; n++) begin
                r_mat[n] <= (n % 5 == 0) ? ONE_W : '0;
            end
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_row <= '0;
                        r_col <= '0;
                        r_sub <= '0;
                        r_ph <= '0;
                        r_vert <= (i_kind == KIND_VERTEX);
                        r_v[0] <= i_vec_x;
                        r_v[1] <= i_vec_y;
                        r_v[2] <= i_vec_z;
                        r_ax[0] <= i_axis_x;
                        r_ax[1] <= i_axis_y;
                        r_ax[2] <= i_axis_z;
                        r_neg <= i_angle[WORD_W-1];
                        // The magnitude of the most negative angle needs the full 32 bits.
                        r_mag <= {2'b00, (i_angle[WORD_W-1] ? WORD_W'(-i_angle) : i_angle)};
                        r_cnt <= CNT_W'(RED_STEPS - 1);
                        case (i_kind)
                            KIND_WRITE:  r_mat[i_entry_index] <= i_entry_value;
                            KIND_ROTATE: r_state <= ST_REDUCE;
                            default:     r_state <= ST_XFORM;
                        endcase
                    end
                end
                ST_REDUCE: begin
                    if (r_mag >= red_sub) r_mag <= r_mag - red_sub;
                    if (r_cnt == '0) r_state <= ST_FOLD;
                    else r_cnt <= r_cnt - 1'b1;
                end
                ST_FOLD: begin
                    r_z <= WORD_W'(f3);
                    r_flip <= f_flip;
                    r_x <= X_INIT;
                    r_y <= '0;
                    r_cnt <= '0;
                    r_state <= ST_CORDIC;
                end
                ST_CORDIC: begin
                    if (r_cnt == CNT_W'(CORDIC_N)) begin
                        r_s <= r_flip ? -r_y : r_y;
                        r_c <= c_fin;
                        r_t <= ONE_W - c_fin;
                        r_state <= ST_COEF;
                    end else begin
                        if (r_z >= 0) begin
                            r_x <= r_x - ys;
                            r_y <= r_y + xs;
                            r_z <= r_z - at;
                        end else begin
                            r_x <= r_x + ys;
                            r_y <= r_y - xs;
                            r_z <= r_z + at;
                        end
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_COEF, ST_MATMUL, ST_XFORM: begin
                    if (r_ph == 2'd0) begin
                        r_prod <= mul_p;
                        r_ph <= 2'd1;
                    end else if (r_ph == 2'd1) begin
                        if (r_state == ST_COEF && r_sub == 2'd0) r_tmp <= r_prod[WORD_W-1:0];
                        else r_acc <= acc_next;
                        if (r_sub == last_sub) begin
                            r_ph <= 2'd2;
                        end else begin
                            r_sub <= r_sub + 1'b1;
                            r_ph <= 2'd0;
                        end
                    end else begin
                        // Store the finished dot product and move to the next one.
                        r_sub <= '0;
                        r_ph <= 2'd0;
                        if (r_state == ST_XFORM) begin
                            r_res[r_row] <= fin;
                            r_row <= r_row + 1'b1;
                            if (r_row == 2'd2) begin
                                r_state <= ST_IDLE;
                            end
                        end else begin
                            if (r_state == ST_COEF) r_rm[r_row][r_col] <= r_acc[RM_SHIFT +: RM_W];
                            else r_newm[r_col][r_row] <= fin;
                            if (grid_last) begin
                                r_row <= '0;
                                r_col <= '0;
                                r_state <= (r_state == ST_COEF) ? ST_MATMUL : ST_COMMIT;
                            end else if (r_row == 2'd2) begin
                                r_row <= '0;
                                r_col <= r_col + 1'b1;
                            end else begin
                                r_row <= r_row + 1'b1;
                            end
                        end
                    end
                end
                ST_COMMIT: begin
                    for (int j = 0; j < 3; j++) begin
                        for (int i = 0; i < 3; i++) begin
                            r_mat[j*4 + i] <= r_newm[j][i];
                        end
                    end
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
